// ===== rtl/ir_pulse_capture_playback_assert.svh =====
// Assertion macros shared by the IR pulse capture and playback RTL.
// Uses the clk and rst signals of the including module; no other dependencies.
`ifndef IR_PULSE_CAPTURE_PLAYBACK_ASSERT_SVH
`define IR_PULSE_CAPTURE_PLAYBACK_ASSERT_SVH

`ifndef NO_ASSERTIONS
// cond must hold at every clock edge out of reset
`define IRPCP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// post must hold in the cycle after pre
`define IRPCP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define IRPCP_ASSERT_ALWAYS(label, cond, msg)
`define IRPCP_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== rtl/ir_pcp_pkg.sv =====
// Types, codes and constants of the IR pulse capture and playback block.
// No dependencies; imported by every module of the block.
package ir_pcp_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int VALUE_W        = 16;
  localparam int PRESCALE_W     = 8;
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 8;

  localparam logic [VALUE_W-1:0] END_WORD = 16'hFFFF;
  localparam logic [16:0]        END_RUN  = 17'd20;
  localparam logic [2:0]         PRESCALE_RESET = 3'b111;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PRESCALE_SEL  = 4'd0,
    REG_TRANSMIT_MODE = 4'd1
  } reg_index_t;

  typedef enum logic {
    KIND_RX = 1'b0,
    KIND_TX = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNDERRUN = 2'd1,
    ST_BUSY     = 2'd2
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               carrier_on;
    status_t            status;
  } result_t;

  // Start value of an up-counting timer that expires after the word's run
  // length; the caller keeps the low COUNT_BITS bits.
  function automatic logic [32:0] run_start(input logic [VALUE_W-1:0] word);
    logic [16:0] run;
    if (word == END_WORD) begin
      run = END_RUN;
    end else if (word == '0) begin
      run = 17'h10000;
    end else begin
      run = {1'b0, word};
    end
    return 33'd0 - 33'(run);
  endfunction

endpackage

// ===== rtl/ir_pulse_capture_playback.sv =====
// Top level of the IR pulse capture and playback block.
// Depends on ir_pcp_pkg, ir_pcp_core and ir_pcp_skid.
//
// Usage:
//   s_* carries one item per transaction: s_tuser is op (0 base tick with pin
//   sample, 1 transmit duration word), s_tdata holds ir_level and duration.
//   m_* carries zero or one result per item: m_tuser is kind (0 received
//   sample, 1 transmit event), m_tlast marks a receive terminator or a
//   finished playback, m_tdata holds value, carrier_on and status.
//   cfg_* writes register cfg_index (0 prescale_sel, 1 transmit_mode) with
//   cfg_data; cfg_ready is always high and write it only while idle.
// Timing:
//   One item per cycle sustained. A result is registered in the output
//   stage, or in the skid stage while that stalls; the timer step and the
//   reload are one pass of logic between state and output registers.
//   s_tready drops while a configuration write is offered and while the
//   skid stage holds a result behind a stalled m_tready; it returns in the
//   cycle after the receiver takes a result.
// Reset:
//   rst (synchronous) stops the timer and carrier, empties the output
//   stages and sets prescale_sel to 7 and receive mode.
module ir_pulse_capture_playback
  import ir_pcp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,   // [0] ir_level, [16:1] duration, [23:17] zero
  input  logic                   s_tuser,   // [0] op
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [23:0]            m_tdata,   // [15:0] value, [16] carrier_on, [18:17] status
  output logic                   m_tlast,
  output logic                   m_tuser,   // [0] kind
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic    skid_ready;
  logic    item_valid;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready  = 1'b1;
  assign s_tready   = skid_ready && !cfg_valid;
  assign item_valid = s_tvalid && s_tready;

  ir_pcp_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_valid(item_valid),
    .op        (s_tuser),
    .ir_level  (s_tdata[0]),
    .duration  (s_tdata[16:1]),
    .res_valid (res_valid),
    .res       (res)
  );

  ir_pcp_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_res   (res),
    .in_ready (skid_ready),
    .out_valid(m_tvalid),
    .out_res  (out_res),
    .out_ready(m_tready)
  );

  assign m_tdata = {5'd0, out_res.status, out_res.carrier_on, out_res.value};
  assign m_tlast = out_res.last;
  assign m_tuser = out_res.kind;

endmodule

// ===== rtl/ir_pcp_core.sv =====
// Timer, receive edge capture and transmit carrier sequencer of the IR block.
// Depends on ir_pcp_pkg and the assertion macro header.
`include "ir_pulse_capture_playback_assert.svh"

module ir_pcp_core
  import ir_pcp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  input  logic                   op,
  input  logic                   ir_level,
  input  logic [VALUE_W-1:0]     duration,
  output logic                   res_valid,
  output result_t                res
);

  logic [2:0]            prescale_sel, prescale_sel_next;
  logic                  tmode, tmode_next;
  logic                  prev_level, prev_level_next;
  logic                  running, running_next;
  logic [PRESCALE_W-1:0] pcount, pcount_next;
  logic [COUNT_BITS-1:0] tick, tick_next;
  logic                  carrier, carrier_next;
  logic [VALUE_W-1:0]    held_word;
  logic                  held_load;
  logic                  held_full, held_full_next;
  logic                  end_seen, end_seen_next;

  logic [PRESCALE_W:0]   pinc;
  logic [PRESCALE_W:0]   pdiv;
  logic                  pwrap;
  logic [COUNT_BITS-1:0] tick_inc;
  logic                  expire;
  logic [32:0]           tick_ext;
  logic [VALUE_W-1:0]    tick_sat;
  logic [32:0]           start_word;
  logic [32:0]           start_held;
  logic                  changed;

  // prescaler and timer advance, capture value, reload start values, level change
  always_comb begin
    pinc     = {1'b0, pcount} + 1'b1;
    pdiv     = (PRESCALE_W+1)'(1) << ({1'b0, prescale_sel} + 4'd1);
    pwrap    = pinc >= pdiv;
    tick_inc = tick + 1'b1;
    expire   = pwrap && (tick_inc == '0);
    tick_ext = 33'(tick);
    tick_sat = (tick_ext > 33'h0FFFF) ? END_WORD : tick_ext[VALUE_W-1:0];
    start_word = run_start(duration);
    start_held = run_start(held_word);
    changed  = ir_level != prev_level;
  end

  always_comb begin
    prescale_sel_next = prescale_sel;
    tmode_next        = tmode;
    prev_level_next   = prev_level;
    running_next      = running;
    pcount_next       = pcount;
    tick_next         = tick;
    carrier_next      = carrier;
    held_full_next    = held_full;
    end_seen_next     = end_seen;
    held_load         = 1'b0;
    res_valid         = 1'b0;
    res               = '{kind: KIND_RX, value: '0, last: 1'b0, carrier_on: 1'b0,
                          status: ST_OK};

    if (cfg_write) begin
      case (cfg_index)
        REG_PRESCALE_SEL: begin
          prescale_sel_next = cfg_data[2:0];
        end
        REG_TRANSMIT_MODE: begin
          tmode_next = cfg_data[0];
          // mode change drops everything in flight
          if (cfg_data[0] != tmode) begin
            running_next   = 1'b0;
            pcount_next    = '0;
            tick_next      = '0;
            carrier_next   = 1'b0;
            held_full_next = 1'b0;
            end_seen_next  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (item_valid && op) begin
      if (!tmode) begin
        // duration word ignored while capturing
      end else if (!running) begin
        running_next   = 1'b1;
        carrier_next   = 1'b1;
        held_full_next = 1'b0;
        end_seen_next  = duration == END_WORD;
        tick_next      = start_word[COUNT_BITS-1:0];
        pcount_next    = '0;
        res_valid      = 1'b1;
        res            = '{kind: KIND_TX, value: duration, last: 1'b0, carrier_on: 1'b1,
                           status: ST_OK};
      end else if (held_full) begin
        res_valid = 1'b1;
        res       = '{kind: KIND_TX, value: duration, last: 1'b0, carrier_on: carrier,
                      status: ST_BUSY};
      end else begin
        held_load      = 1'b1;
        held_full_next = 1'b1;
        end_seen_next  = end_seen || (duration == END_WORD);
        res_valid      = 1'b1;
        res            = '{kind: KIND_TX, value: duration, last: 1'b0, carrier_on: carrier,
                           status: ST_OK};
      end
    end else if (item_valid) begin
      prev_level_next = ir_level;
      if (!tmode) begin
        if (!running) begin
          // only a falling edge arms the timer
          if (changed && !ir_level) begin
            running_next = 1'b1;
            tick_next    = '0;
            pcount_next  = '0;
          end
        end else if (changed) begin
          tick_next   = '0;
          pcount_next = '0;
          res_valid   = 1'b1;
          res         = '{kind: KIND_RX, value: tick_sat, last: 1'b0, carrier_on: 1'b0,
                          status: ST_OK};
        end else begin
          pcount_next = pwrap ? '0 : pinc[PRESCALE_W-1:0];
          tick_next   = pwrap ? tick_inc : tick;
          if (expire) begin
            running_next = 1'b0;
            res_valid    = 1'b1;
            res          = '{kind: KIND_RX, value: END_WORD, last: 1'b1, carrier_on: 1'b0,
                             status: ST_OK};
          end
        end
      end else if (running) begin
        pcount_next = pwrap ? '0 : pinc[PRESCALE_W-1:0];
        tick_next   = pwrap ? tick_inc : tick;
        if (expire) begin
          if (!held_full) begin
            running_next = 1'b0;
            carrier_next = 1'b0;
            res_valid    = 1'b1;
            res          = '{kind: KIND_TX, value: '0, last: end_seen, carrier_on: 1'b0,
                             status: end_seen ? ST_OK : ST_UNDERRUN};
          end else begin
            // reload from the holding register and flip the carrier
            carrier_next   = ~carrier;
            held_full_next = 1'b0;
            tick_next      = start_held[COUNT_BITS-1:0];
            pcount_next    = '0;
            res_valid      = 1'b1;
            res            = '{kind: KIND_TX, value: held_word, last: 1'b0,
                               carrier_on: ~carrier, status: ST_OK};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_sel <= PRESCALE_RESET;
      tmode        <= 1'b0;
      prev_level   <= 1'b1;
      running      <= 1'b0;
      pcount       <= '0;
      tick         <= '0;
      carrier      <= 1'b0;
      held_full    <= 1'b0;
      end_seen     <= 1'b0;
    end else begin
      prescale_sel <= prescale_sel_next;
      tmode        <= tmode_next;
      prev_level   <= prev_level_next;
      running      <= running_next;
      pcount       <= pcount_next;
      tick         <= tick_next;
      carrier      <= carrier_next;
      held_full    <= held_full_next;
      end_seen     <= end_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (held_load) begin
      held_word <= duration;
    end
  end

  `IRPCP_ASSERT_ALWAYS(a_held_needs_timer, !held_full || running,
                       "holding register full while timer stopped")
  `IRPCP_ASSERT_ALWAYS(a_carrier_in_tx, !carrier || (running && tmode),
                       "carrier on outside a running playback")
  `IRPCP_ASSERT_NEXT(a_stop_clears_carrier,
                     res_valid && res.kind == KIND_TX && (res.last || res.status == ST_UNDERRUN),
                     !carrier && !running, "carrier stop left timer running")

endmodule

// ===== rtl/ir_pcp_skid.sv =====
// Output register with a one-entry skid stage for the IR block result stream.
// Depends on ir_pcp_pkg and the assertion macro header.
`include "ir_pulse_capture_playback_assert.svh"

module ir_pcp_skid
  import ir_pcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_res,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  logic    skid_valid;
  result_t skid_res;
  logic    out_fire;

  assign in_ready = !skid_valid;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid || out_fire) begin
        out_res   <= in_res;
        out_valid <= 1'b1;
      end else begin
        // hold the new result while the output stalls
        skid_res   <= in_res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  `IRPCP_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid || out_valid,
                       "skid entry without an output entry")
  `IRPCP_ASSERT_NEXT(a_stall_fills_skid, in_valid && in_ready && out_valid && !out_ready,
                     skid_valid, "stalled result not held in skid stage")
  `IRPCP_ASSERT_NEXT(a_skid_drains, skid_valid && out_ready, !skid_valid && out_valid,
                     "skid stage did not drain into output")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for ir_pulse_capture_playback: receive capture and transmit playback.
// Depends on ir_pcp_pkg and the RTL of the block. A predictor of the block, kept in a small
// class, computes the expected events and checks each one that the block produces.
module testbench;
  import ir_pcp_pkg::*;

  localparam logic OP_TICK       = 1'b0;
  localparam logic OP_WORD       = 1'b1;
  localparam logic MODE_RECEIVE  = 1'b0;
  localparam logic MODE_TRANSMIT = 1'b1;
  localparam int   RANDOM_ITEMS  = 600;
  localparam int   HOLDOFF_CYCLES = 400;

  class ir_event_board;
    logic [2:0]  sel;
    logic        tx_mode;
    logic        prev_lvl;
    bit          running;
    int unsigned presc;
    logic [15:0] timer_value;
    logic        car;
    logic [15:0] held;
    bit          held_full;
    bit          end_mark;
    result_t     awaited_events[$];
    int unsigned mismatches;
    int unsigned events_checked;
    int unsigned terminators;
    int unsigned underruns;
    int unsigned busy_rejects;
    int unsigned finished_runs;

    function new();
      sel = PRESCALE_RESET;
      tx_mode = MODE_RECEIVE;
      prev_lvl = 1'b1;
      held = '0;
      stop_all();
    endfunction

    function void stop_all();
      running = 0;
      presc = 0;
      timer_value = '0;
      car = 1'b0;
      held_full = 0;
      end_mark = 0;
    endfunction

    function void configure(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PRESCALE_SEL: sel = data[2:0];
        REG_TRANSMIT_MODE: begin
          if (data[0] != tx_mode) stop_all();
          tx_mode = data[0];
        end
        default: ;
      endcase
    endfunction

    // Timer counts up from 2^16 minus the run length and expires on wrap.
    function void load_run(logic [15:0] word);
      logic [16:0] run;
      if (word == END_WORD) begin
        run = END_RUN;
      end else if (word == '0) begin
        run = 17'h10000;
      end else begin
        run = {1'b0, word};
      end
      timer_value = 16'(17'h10000 - run);
      presc = 0;
    endfunction

    // True when the timer wrapped to zero on this base tick.
    function bit step_timer();
      presc++;
      if (presc < (32'd1 << (int'(sel) + 1))) return 0;
      presc = 0;
      timer_value = timer_value + 16'd1;
      return timer_value == '0;
    endfunction

    function void note_item(logic op, logic lvl, logic [15:0] word);
      result_t r;
      bit      emits;
      bit      changed;
      emits = 0;
      r = '0;
      if (op == OP_WORD) begin
        if (tx_mode == MODE_TRANSMIT) begin
          emits = 1;
          r.kind = KIND_TX;
          r.value = word;
          r.last = 1'b0;
          r.status = ST_OK;
          if (!running) begin
            running = 1;
            car = 1'b1;
            held_full = 0;
            end_mark = (word == END_WORD);
            load_run(word);
          end else if (held_full) begin
            r.status = ST_BUSY;
            busy_rejects++;
          end else begin
            held = word;
            held_full = 1;
            if (word == END_WORD) end_mark = 1;
          end
          r.carrier_on = car;
        end
      end else begin
        changed = (lvl != prev_lvl);
        prev_lvl = lvl;
        if (tx_mode == MODE_RECEIVE) begin
          if (!running) begin
            if (changed && lvl == 1'b0) begin
              running = 1;
              timer_value = '0;
              presc = 0;
            end
          end else if (changed) begin
            emits = 1;
            r = '{KIND_RX, timer_value, 1'b0, 1'b0, ST_OK};
            timer_value = '0;
            presc = 0;
          end else if (step_timer()) begin
            running = 0;
            presc = 0;
            emits = 1;
            terminators++;
            r = '{KIND_RX, END_WORD, 1'b1, 1'b0, ST_OK};
          end
        end else if (running && step_timer()) begin
          emits = 1;
          if (!held_full) begin
            running = 0;
            car = 1'b0;
            presc = 0;
            if (end_mark) finished_runs++;
            else underruns++;
            r = '{KIND_TX, 16'h0000, end_mark, 1'b0, end_mark ? ST_OK : ST_UNDERRUN};
          end else begin
            car = ~car;
            held_full = 0;
            load_run(held);
            r = '{KIND_TX, held, 1'b0, car, ST_OK};
          end
        end
      end
      if (emits) awaited_events.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event, expected none, actual kind %0d value 0x%0h",
                 $time, got.kind, got.value);
        return;
      end
      want = awaited_events.pop_front();
      events_checked++;
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("value", want.value, got.value);
      compare_field("last", 16'(want.last), 16'(got.last));
      compare_field("carrier_on", 16'(want.carrier_on), 16'(got.carrier_on));
      compare_field("status", 16'(want.status), 16'(got.status));
    endfunction

    function int unsigned outstanding();
      return awaited_events.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [23:0]            s_tdata;   // [0] ir_level, [16:1] duration, [23:17] zero
  logic                   s_tuser;   // [0] op
  logic                   m_tvalid;
  logic                   m_tready;
  logic [23:0]            m_tdata;   // [15:0] value, [16] carrier_on, [18:17] status
  logic                   m_tlast;
  logic                   m_tuser;   // [0] kind
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ir_event_board board = new();
  int unsigned   burst_left;
  bit            gaps_on;
  bit            holdoff_request;
  int unsigned   items_sent;
  int unsigned   reg_writes;

  ir_pulse_capture_playback dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout: stimulus or expected events did not complete");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(logic op, logic lvl, logic [15:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, word, lvl};
    do @(posedge clk); while (!s_tready);
    board.note_item(op, lvl, word);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic run_ticks(int unsigned n, logic lvl);
    repeat (n) send_item(OP_TICK, lvl, 16'($urandom));
  endtask

  // Drop valid and hold until every expected event has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (board.outstanding() != 0);
  endtask

  task automatic apply_config(logic [2:0] sel, logic mode);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PRESCALE_SEL;
    cfg_data <= {5'($urandom), sel};
    do @(posedge clk); while (!cfg_ready);
    board.configure(REG_PRESCALE_SEL, cfg_data);
    @(negedge clk);
    cfg_index <= REG_TRANSMIT_MODE;
    cfg_data <= {7'($urandom), mode};
    do @(posedge clk); while (!cfg_ready);
    board.configure(REG_TRANSMIT_MODE, cfg_data);
    reg_writes += 2;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall patterns of random style, plus a long hold-off on request.
  initial begin
    int unsigned stretch_left;
    int unsigned holdoff_left;
    int unsigned pattern;
    bit          ready_next;
    m_tready = 1'b0;
    stretch_left = 0;
    holdoff_left = 0;
    pattern = 0;
    forever begin
      @(negedge clk);
      if (holdoff_request) begin
        holdoff_request = 0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        ready_next = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          pattern = $urandom_range(0, 3);
          stretch_left = $urandom_range(16, 256);
        end
        stretch_left--;
        case (pattern)
          0: ready_next = 1'b1;
          1: ready_next = ($urandom_range(0, 3) != 0);
          2: ready_next = 1'($urandom_range(0, 1));
          default: ready_next = ((stretch_left % 4) == 0);
        endcase
      end
      m_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_result('{kind_t'(m_tuser), m_tdata[15:0], m_tlast, m_tdata[16],
                           status_t'(m_tdata[18:17])});
    end
  end

  initial begin
    logic [2:0]  seg_sel;
    logic        seg_mode;
    logic        pin;
    logic [15:0] word;
    int unsigned seg_len;
    int unsigned feed_odds;
    int unsigned run_left;
    int unsigned counted;
    int unsigned pick;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_TICK;
    cfg_valid = 1'b0;
    cfg_index = REG_PRESCALE_SEL;
    cfg_data = '0;
    burst_left = 0;
    gaps_on = 1;
    holdoff_request = 0;
    items_sent = 0;
    reg_writes = 0;
    counted = 0;
    run_left = 0;
    pin = 1'b1;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Receive: short pulses, an ignored word, a zero-length space.
    apply_config(3'd0, MODE_RECEIVE);
    run_ticks(2, 1'b1);
    run_ticks(5, 1'b0);
    run_ticks(3, 1'b1);
    send_item(OP_WORD, 1'b0, 16'hA5C3);
    run_ticks(1, 1'b0);
    run_ticks(1, 1'b1);

    // Transmit: reload, busy, end word held, word after the end, underrun.
    apply_config(3'd0, MODE_TRANSMIT);
    send_item(OP_WORD, 1'b1, 16'd1);
    send_item(OP_WORD, 1'b1, 16'd2);
    send_item(OP_WORD, 1'b0, 16'd3);
    run_ticks(2, 1'b1);
    send_item(OP_WORD, 1'b0, END_WORD);
    run_ticks(46, 1'b0);
    send_item(OP_WORD, 1'b1, 16'd5);
    run_ticks(12, 1'b1);
    send_item(OP_WORD, 1'b1, END_WORD);
    run_ticks(42, 1'b0);

    // Slowest prescale, then a mode change while running with a held word.
    apply_config(3'd7, MODE_TRANSMIT);
    send_item(OP_WORD, 1'b1, 16'd1);
    run_ticks(260, 1'b1);
    send_item(OP_WORD, 1'b1, 16'd3);
    send_item(OP_WORD, 1'b1, 16'd4);
    run_ticks(100, 1'b0);
    apply_config(3'd7, MODE_RECEIVE);
    run_ticks(3, 1'b1);
    run_ticks(300, 1'b0);
    run_ticks(1, 1'b1);

    // A zero word loads a full-length run; a mode change then stops it.
    gaps_on = 0;
    apply_config(3'd0, MODE_TRANSMIT);
    send_item(OP_WORD, 1'b0, 16'd0);
    send_item(OP_WORD, 1'b0, 16'd9);
    run_ticks(30, 1'b1);
    apply_config(3'd0, MODE_RECEIVE);

    // Back-pressure: receiver holds off while words keep coming.
    apply_config(3'd1, MODE_TRANSMIT);
    holdoff_request = 1;
    send_item(OP_WORD, 1'b0, 16'd3);
    repeat (40) send_item(OP_WORD, 1'($urandom), 16'($urandom));
    run_ticks(40, 1'b0);
    drain_results();

    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      seg_sel = (pick < 10) ? 3'($urandom_range(0, 1)) :
                (pick < 14) ? 3'($urandom_range(2, 6)) : 3'd7;
      seg_mode = 1'($urandom_range(0, 1));
      apply_config(seg_sel, seg_mode);
      gaps_on = ($urandom_range(0, 3) != 0);
      seg_len = $urandom_range(60, 160);
      feed_odds = $urandom_range(0, 60);
      repeat (seg_len) begin
        if ($urandom_range(0, 149) == 0) drain_results();
        if (seg_mode == MODE_RECEIVE) begin
          if ($urandom_range(0, 24) == 0) begin
            send_item(OP_WORD, 1'($urandom), 16'($urandom));
          end else begin
            if (run_left == 0) begin
              pin = ~pin;
              run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                      : $urandom_range(1, 12);
            end
            run_left--;
            send_item(OP_TICK, pin, 16'($urandom));
            counted++;
          end
        end else begin
          pick = $urandom_range(0, 19);
          word = (pick == 0) ? END_WORD :
                 (seg_sel > 3'd4) ? 16'($urandom_range(1, 4)) : 16'($urandom_range(1, 40));
          if (!board.running && $urandom_range(0, 3) != 0) begin
            send_item(OP_WORD, 1'($urandom), word);
          end else if (board.running && !board.held_full &&
                       $urandom_range(0, feed_odds) == 0) begin
            send_item(OP_WORD, 1'($urandom), word);
          end else if (board.held_full && $urandom_range(0, 15) == 0) begin
            send_item(OP_WORD, 1'($urandom), 16'($urandom));
          end else begin
            send_item(OP_TICK, 1'($urandom), 16'($urandom));
          end
          counted++;
        end
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("Covered %0d items, %0d events checked, %0d register writes.",
             items_sent, board.events_checked, reg_writes);
    $display("Terminators %0d, underruns %0d, finished playbacks %0d, busy rejects %0d.",
             board.terminators, board.underruns, board.finished_runs, board.busy_rejects);
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
